[rtl/core/joystick_axis_scaler_defines.svh]
// assertion macros for the joystick axis scaler
// included by files that carry concurrent checks, no other dependencies
`ifndef JOYSTICK_AXIS_SCALER_DEFINES_SVH
`define JOYSTICK_AXIS_SCALER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define JAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define JAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/jas_pkg.sv]
// shared types and constants for the joystick axis scaler
// no dependencies
package jas_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int PCT_W       = 7;
  localparam int MASK_W      = 4;
  localparam int MARGIN_W    = 6;
  localparam int IDX_W       = 3;
  // quotient never exceeds 50, so it fits in six bits
  localparam int QUOT_W      = $clog2(51);
  localparam int NUM_W       = SAMPLE_BITS + QUOT_W;
  localparam int CNT_W       = $clog2(QUOT_W);

  localparam logic [PCT_W-1:0] PCT_ZERO = PCT_W'(0);
  localparam logic [PCT_W-1:0] PCT_MID  = PCT_W'(50);
  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  localparam logic [SAMPLE_BITS-1:0] CENTRE_RESET = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
  localparam logic [SAMPLE_BITS-1:0] MIN_RESET    = SAMPLE_BITS'(100);
  localparam logic [SAMPLE_BITS-1:0] MAX_RESET    = SAMPLE_BITS'(922);
  localparam logic [SAMPLE_BITS-1:0] BAND_RESET   = SAMPLE_BITS'(50);
  localparam logic [MARGIN_W-1:0]    MARGIN_RESET = MARGIN_W'(15);

  typedef enum logic [IDX_W-1:0] {
    REG_X_MIN  = 3'd0,
    REG_X_MAX  = 3'd1,
    REG_Y_MIN  = 3'd2,
    REG_Y_MAX  = 3'd3,
    REG_BAND   = 3'd4,
    REG_MARGIN = 3'd5,
    REG_INVERT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
  } jas_in_t;

  typedef struct packed {
    logic [PCT_W-1:0]  x_percent;
    logic [PCT_W-1:0]  y_percent;
    logic [MASK_W-1:0] direction_mask;
  } jas_out_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x_min;
    logic [SAMPLE_BITS-1:0] x_max;
    logic [SAMPLE_BITS-1:0] y_min;
    logic [SAMPLE_BITS-1:0] y_max;
    logic [SAMPLE_BITS-1:0] dead_band;
    logic [MARGIN_W-1:0]    margin;
    logic                   invert;
  } jas_cfg_t;

endpackage

[rtl/core/jas_cfg.sv]
// configuration register file of the joystick axis scaler
// depends on jas_pkg
module jas_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [jas_pkg::IDX_W-1:0]       wr_index,
  input  logic [jas_pkg::SAMPLE_BITS-1:0] wr_data,
  output jas_pkg::jas_cfg_t               cfg
);

  jas_pkg::jas_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min     <= jas_pkg::MIN_RESET;
      cfg_r.x_max     <= jas_pkg::MAX_RESET;
      cfg_r.y_min     <= jas_pkg::MIN_RESET;
      cfg_r.y_max     <= jas_pkg::MAX_RESET;
      cfg_r.dead_band <= jas_pkg::BAND_RESET;
      cfg_r.margin    <= jas_pkg::MARGIN_RESET;
      cfg_r.invert    <= 1'b1;
    end else if (wr_en) begin
      unique case (jas_pkg::reg_idx_t'(wr_index))
        jas_pkg::REG_X_MIN:  cfg_r.x_min     <= wr_data;
        jas_pkg::REG_X_MAX:  cfg_r.x_max     <= wr_data;
        jas_pkg::REG_Y_MIN:  cfg_r.y_min     <= wr_data;
        jas_pkg::REG_Y_MAX:  cfg_r.y_max     <= wr_data;
        jas_pkg::REG_BAND:   cfg_r.dead_band <= wr_data;
        jas_pkg::REG_MARGIN: cfg_r.margin    <= wr_data[jas_pkg::MARGIN_W-1:0];
        jas_pkg::REG_INVERT: cfg_r.invert    <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/jas_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on jas_pkg; quotient must fit in QUOT_W bits
module jas_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [jas_pkg::NUM_W-1:0]       num,
  input  logic [jas_pkg::SAMPLE_BITS-1:0] den,
  output logic                            busy,
  output logic                            done,
  output logic [jas_pkg::QUOT_W-1:0]      quot
);

  logic                          busy_r;
  logic                          done_r;
  logic [jas_pkg::CNT_W-1:0]     cnt_r;
  logic [jas_pkg::NUM_W-1:0]     rem_r;
  logic [jas_pkg::NUM_W-1:0]     dsh_r;
  logic [jas_pkg::QUOT_W-1:0]    quot_r;
  logic                          ge;

  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= jas_pkg::CNT_W'(jas_pkg::QUOT_W - 1);
        rem_r  <= num;
        // divisor aligned under the top quotient bit
        dsh_r  <= jas_pkg::NUM_W'(den) << (jas_pkg::QUOT_W - 1);
        quot_r <= '0;
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        quot_r <= {quot_r[jas_pkg::QUOT_W-2:0], ge};
        dsh_r  <= dsh_r >> 1;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule

[rtl/core/joystick_axis_scaler.sv]
// joystick axis scaler: centre dead band, per-side scaling to 0..100, direction mask
// an item inside the dead band goes from S_PREP_X straight to S_DONE, where its result is
// registered; otherwise each axis that needs a quotient passes through the bit-serial divider
// throughput: one item at a time, next item taken the cycle after its result is registered
// a calibrate item loads the centres from its samples and gives no result
// synchronous active-low reset: registers to defaults, centres to mid-scale, no result pending
`include "joystick_axis_scaler_defines.svh"

module joystick_axis_scaler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  jas_pkg::jas_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output jas_pkg::jas_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jas_pkg::IDX_W-1:0]       cfg_index,
  input  logic [jas_pkg::SAMPLE_BITS-1:0] cfg_data
);

  localparam int SB = jas_pkg::SAMPLE_BITS;
  localparam int PW = jas_pkg::PCT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP_X,
    S_DIV_X,
    S_PREP_Y,
    S_DIV_Y,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                         use_div;
    logic [PW-1:0]                base;
    logic [jas_pkg::NUM_W-1:0]    num;
    logic [SB-1:0]                den;
  } prep_t;

  function automatic logic in_band(input logic [SB-1:0] s, input logic [SB-1:0] c,
                                   input logic [SB-1:0] band);
    logic [SB-1:0] delta;
    delta = (s >= c) ? (s - c) : (c - s);
    return (delta <= band);
  endfunction

  // x * 50 as shifts and adds
  function automatic logic [jas_pkg::NUM_W-1:0] times_fifty(input logic [SB-1:0] v);
    logic [jas_pkg::NUM_W-1:0] w;
    w = jas_pkg::NUM_W'(v);
    return (w << 5) + (w << 4) + (w << 1);
  endfunction

  function automatic prep_t axis_prep(input logic [SB-1:0] s, input logic [SB-1:0] c,
                                      input logic [SB-1:0] lo, input logic [SB-1:0] hi);
    prep_t p;
    p.use_div = 1'b0;
    p.base    = jas_pkg::PCT_MID;
    p.num     = '0;
    p.den     = '0;
    if (s <= c) begin
      if (s < lo) begin
        p.base = jas_pkg::PCT_ZERO;
      end else if (c != lo) begin
        p.use_div = 1'b1;
        p.base    = jas_pkg::PCT_ZERO;
        p.num     = times_fifty(s - lo);
        p.den     = c - lo;
      end
    end else if (s > hi) begin
      p.base = jas_pkg::PCT_FULL;
    end else begin
      // here hi > c, so the divisor is never zero
      p.use_div = 1'b1;
      p.num     = times_fifty(s - c);
      p.den     = hi - c;
    end
    return p;
  endfunction

  jas_pkg::jas_cfg_t cfg;

  state_t            state_r;
  logic [SB-1:0]     xs_r;
  logic [SB-1:0]     ys_r;
  logic [SB-1:0]     xc_r;
  logic [SB-1:0]     yc_r;
  logic [PW-1:0]     xv_r;
  logic [PW-1:0]     yv_r;
  logic              out_valid_r;
  jas_pkg::jas_out_t out_data_r;

  logic                          both_band;
  logic                          sel_y;
  prep_t                         prep;
  logic                          div_start;
  logic                          div_busy;
  logic                          div_done;
  logic [jas_pkg::QUOT_W-1:0]    div_quot;
  logic [PW-1:0]                 xf;
  logic [PW-1:0]                 yf;
  logic [PW:0]                   mid_lo;
  logic [PW:0]                   mid_hi;
  logic [jas_pkg::MASK_W-1:0]    dir_mask;

  jas_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);

  assign both_band = in_band(xs_r, xc_r, cfg.dead_band) && in_band(ys_r, yc_r, cfg.dead_band);
  assign sel_y     = (state_r == S_PREP_Y);

  always_comb begin
    if (sel_y) begin
      prep = axis_prep(ys_r, yc_r, cfg.y_min, cfg.y_max);
    end else begin
      prep = axis_prep(xs_r, xc_r, cfg.x_min, cfg.x_max);
    end
  end

  assign div_start = prep.use_div &&
                     (((state_r == S_PREP_X) && !both_band) || (state_r == S_PREP_Y));

  jas_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prep.num),
    .den   (prep.den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // inversion and direction flags; margin compared without going negative
  assign xf     = cfg.invert ? (jas_pkg::PCT_FULL - xv_r) : xv_r;
  assign yf     = cfg.invert ? (jas_pkg::PCT_FULL - yv_r) : yv_r;
  assign mid_lo = {1'b0, jas_pkg::PCT_MID};
  assign mid_hi = {1'b0, jas_pkg::PCT_MID} + (PW + 1)'(cfg.margin);

  always_comb begin
    dir_mask    = '0;
    dir_mask[0] = (({1'b0, yf} + (PW + 1)'(cfg.margin)) <= mid_lo);
    dir_mask[1] = ({1'b0, yf} > mid_hi);
    dir_mask[2] = (({1'b0, xf} + (PW + 1)'(cfg.margin)) <= mid_lo);
    dir_mask[3] = ({1'b0, xf} > mid_hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      xc_r        <= jas_pkg::CENTRE_RESET;
      yc_r        <= jas_pkg::CENTRE_RESET;
    end else begin
      // in S_DONE the result register is reloaded below instead
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.op) begin
              xc_r <= in_data.x_sample;
              yc_r <= in_data.y_sample;
            end else begin
              xs_r    <= in_data.x_sample;
              ys_r    <= in_data.y_sample;
              state_r <= S_PREP_X;
            end
          end
        end
        S_PREP_X: begin
          if (both_band) begin
            xv_r    <= jas_pkg::PCT_MID;
            yv_r    <= jas_pkg::PCT_MID;
            state_r <= S_DONE;
          end else begin
            xv_r    <= prep.base;
            state_r <= prep.use_div ? S_DIV_X : S_PREP_Y;
          end
        end
        S_DIV_X: begin
          if (div_done) begin
            xv_r    <= xv_r + PW'(div_quot);
            state_r <= S_PREP_Y;
          end
        end
        S_PREP_Y: begin
          yv_r    <= prep.base;
          state_r <= prep.use_div ? S_DIV_Y : S_DONE;
        end
        S_DIV_Y: begin
          if (div_done) begin
            yv_r    <= yv_r + PW'(div_quot);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // wait here only while the previous item is still unclaimed
          if (!out_valid_r || out_ready) begin
            out_data_r.x_percent      <= xf;
            out_data_r.y_percent      <= yf;
            out_data_r.direction_mask <= dir_mask;
            out_valid_r               <= 1'b1;
            state_r                   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `JAS_ASSERT_IMPLY(a_div_idle_on_start, clk, rst_n, div_start, !div_busy, "divider started while busy")
  `JAS_ASSERT_IMPLY(a_div_done_state, clk, rst_n, div_done, (state_r == S_DIV_X) || (state_r == S_DIV_Y), "divider finished outside a divide state")
  `JAS_ASSERT_IMPLY(a_out_range, clk, rst_n, out_valid_r, (out_data_r.x_percent <= jas_pkg::PCT_FULL) && (out_data_r.y_percent <= jas_pkg::PCT_FULL), "axis value above full scale")
  `JAS_ASSERT_NEXT(a_centre_capture, clk, rst_n, in_valid && in_ready && in_data.op, (xc_r == $past(in_data.x_sample)) && (yc_r == $past(in_data.y_sample)), "centres not captured")

endmodule
